// ----- design/u8lb_pkg.sv -----
package u8lb_pkg;

    // Input opcodes
    localparam logic OP_TEXT  = 1'b0;
    localparam logic OP_GLYPH = 1'b1;

    // Configuration register indexes
    localparam logic [2:0] REG_LINE_WIDTH      = 3'd0;
    localparam logic [2:0] REG_SPACE_ADVANCE   = 3'd1;
    localparam logic [2:0] REG_LETTER_GAP      = 3'd2;
    localparam logic [2:0] REG_LATIN_ADVANCE   = 3'd3;
    localparam logic [2:0] REG_MAX_GLYPH_WIDTH = 3'd4;
    localparam logic [2:0] REG_LETTER_FIRST    = 3'd5;
    localparam logic [2:0] REG_LETTER_LAST     = 3'd6;

    // Scan modes
    localparam logic [1:0] MODE_FIT  = 2'd0;
    localparam logic [1:0] MODE_WORD = 2'd1;
    localparam logic [1:0] MODE_DONE = 2'd2;

    // Code points
    localparam logic [15:0] CP_REPLACEMENT = 16'hFFFD;
    localparam logic [15:0] CP_SPACE       = 16'h0020;
    localparam logic [15:0] CP_LATIN_FIRST = 16'h0021;
    localparam logic [15:0] CP_LATIN_END   = 16'h007F;

    // Lead byte classes
    localparam logic [7:0] ASCII_END  = 8'h80;
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_CODE = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_CODE = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_CODE = 8'hF0;

    // Sequence length announced by a lead byte; bad leads count as one byte
    function automatic logic [2:0] seq_len(input logic [7:0] lead);
        logic [2:0] len;
        if (lead < ASCII_END)
            len = 3'd1;
        else if ((lead & LEAD2_MASK) == LEAD2_CODE)
            len = 3'd2;
        else if ((lead & LEAD3_MASK) == LEAD3_CODE)
            len = 3'd3;
        else if ((lead & LEAD4_MASK) == LEAD4_CODE)
            len = 3'd4;
        else
            len = 3'd1;
        return len;
    endfunction

    // Decode without checking continuation bytes; four-byte and bad leads give U+FFFD
    function automatic logic [15:0] decode(input logic [7:0] b0, input logic [7:0] b1,
                                           input logic [7:0] b2, input logic [2:0] len);
        logic [15:0] cp;
        if (b0 < ASCII_END)
            cp = {8'h00, b0};
        else if (len == 3'd2)
            cp = {5'b00000, b0[4:0], b1[5:0]};
        else if (len == 3'd3)
            cp = {b0[3:0], b1[5:0], b2[5:0]};
        else
            cp = CP_REPLACEMENT;
        return cp;
    endfunction

endpackage

// ----- design/utf8_greedy_line_break.sv -----
// Channel | Direction | Handshake          | Content
// s       | in        | s_tvalid/s_tready  | text byte or glyph table write, tlast = last byte
// m       | out       | m_tvalid/m_tready  | break length of the finished string
// cfg     | in        | cfg_write          | line metrics and letter range registers
//
// One item per cycle while s_tready is high; a finished string's result is registered.
// A last byte that cuts off a multibyte sequence with bytes behind the lead leaves
// up to two code points over, taken one at a time with s_tready low meanwhile.
// The per-cycle path is decode, one glyph table read and the width add and compare.
// Reset clears string state, valid flags and the glyph table; no clearing pass is needed.
// Output register plus skid entry: input keeps flowing while one result waits.
module utf8_greedy_line_break #(
    parameter int MAX_BYTES   = 1024,
    parameter int GLYPH_SLOTS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // text_byte[7:0], glyph_slot[12:8], glyph_pixels[20:13]
    input  logic        s_tuser,   // opcode
    input  logic        s_tlast,   // last_byte
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [((($clog2(MAX_BYTES + 1)) + 7) / 8) * 8 - 1:0] m_tdata  // break_length
);

    localparam int POS_W       = $clog2(MAX_BYTES + 1);
    localparam int OUT_TDATA_W = ((POS_W + 7) / 8) * 8;
    localparam int SLOT_W      = (GLYPH_SLOTS > 1) ? $clog2(GLYPH_SLOTS) : 1;

    // configuration registers
    logic [15:0] line_width_reg;
    logic [7:0]  space_advance_reg;
    logic [3:0]  letter_gap_reg;
    logic [7:0]  latin_advance_reg;
    logic [7:0]  max_glyph_width_reg;
    logic [15:0] letter_first_reg;
    logic [15:0] letter_last_reg;

    // glyph table
    logic [7:0] glyph_widths_reg [GLYPH_SLOTS];

    // string state
    logic [15:0]      used_reg, used_next;
    logic [POS_W-1:0] byte_pos_reg, byte_pos_next;
    logic [POS_W-1:0] stop_pos_reg, stop_pos_next;
    logic [POS_W-1:0] space_pos_reg, space_pos_next;
    logic             space_seen_reg, space_seen_next;
    logic [1:0]       mode_reg, mode_next;
    logic [7:0]       pend_byte_reg [3];
    logic [7:0]       pend_byte_next [3];
    logic [1:0]       pend_cnt_reg, pend_cnt_next;
    logic             flush_reg, flush_next;

    // output register and skid entry
    logic             out_valid_reg, out_valid_next;
    logic [POS_W-1:0] out_data_reg, out_data_next;
    logic             skid_valid_reg, skid_valid_next;
    logic [POS_W-1:0] skid_data_reg, skid_data_next;

    // input fields
    logic [7:0] in_text_byte;
    logic [4:0] in_glyph_slot;
    logic [7:0] in_glyph_pixels;
    logic       s_accept;
    logic       text_step;

    assign in_text_byte    = s_tdata[7:0];
    assign in_glyph_slot   = s_tdata[12:8];
    assign in_glyph_pixels = s_tdata[20:13];

    assign s_tready  = !skid_valid_reg && !flush_reg;
    assign s_accept  = s_tvalid && s_tready;
    assign text_step = (s_accept && (s_tuser == u8lb_pkg::OP_TEXT)) ||
                       (flush_reg && !skid_valid_reg);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TDATA_W'(out_data_reg);

    // Build the byte window: held bytes, then the new byte unless flushing
    logic [7:0] win_byte [4];
    logic [2:0] win_cnt;
    logic       win_last;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (3'(i) < {1'b0, pend_cnt_reg})
                win_byte[i] = pend_byte_reg[i];
            else if ((3'(i) == {1'b0, pend_cnt_reg}) && !flush_reg)
                win_byte[i] = in_text_byte;
            else
                win_byte[i] = 8'h00;
        end
        win_byte[3] = ((pend_cnt_reg == 2'd3) && !flush_reg) ? in_text_byte : 8'h00;
        win_cnt  = {1'b0, pend_cnt_reg} + (flush_reg ? 3'd0 : 3'd1);
        win_last = flush_reg || s_tlast;
    end

    // Take at most one code point from the front of the window
    logic [2:0]  need;
    logic        has_cp;
    logic [15:0] cp;
    logic [2:0]  cp_bytes;
    logic [2:0]  remain;
    logic [7:0]  pend_shift [3];

    always_comb
    begin
        logic [2:0] j;
        need = u8lb_pkg::seq_len(win_byte[0]);
        if (win_cnt >= need)
        begin
            has_cp   = 1'b1;
            cp       = u8lb_pkg::decode(win_byte[0], win_byte[1], win_byte[2], need);
            cp_bytes = need;
        end
        else if (win_last)
        begin
            // cut-off lead at the end of the string stands alone
            has_cp   = 1'b1;
            cp       = u8lb_pkg::CP_REPLACEMENT;
            cp_bytes = 3'd1;
        end
        else
        begin
            has_cp   = 1'b0;
            cp       = u8lb_pkg::CP_REPLACEMENT;
            cp_bytes = 3'd0;
        end
        remain = win_cnt - cp_bytes;
        for (int i = 0; i < 3; i++)
        begin
            j = 3'(i) + cp_bytes;
            pend_shift[i] = (j < 3'd4) ? win_byte[j[1:0]] : 8'h00;
        end
    end

    // Advance of the code point
    logic        is_space;
    logic        is_letter;
    logic        is_latin;
    logic [16:0] letter_diff;
    logic [15:0] letter_idx;
    logic [7:0]  raw_width;
    logic [7:0]  letter_width;
    logic [8:0]  adv;

    always_comb
    begin
        is_space    = (cp == u8lb_pkg::CP_SPACE);
        is_letter   = (letter_first_reg <= letter_last_reg) &&
                      (cp >= letter_first_reg) && (cp <= letter_last_reg);
        is_latin    = (cp >= u8lb_pkg::CP_LATIN_FIRST) && (cp < u8lb_pkg::CP_LATIN_END);
        letter_diff = {1'b0, cp} - {1'b0, letter_first_reg};
        letter_idx  = letter_diff[15:0];
        if (is_letter && (letter_diff < 17'(GLYPH_SLOTS)))
            raw_width = glyph_widths_reg[letter_idx[SLOT_W-1:0]];
        else
            raw_width = 8'h00;
        if ((raw_width == 8'h00) || (raw_width > max_glyph_width_reg))
            letter_width = max_glyph_width_reg;
        else
            letter_width = raw_width;
        if (is_space)
            adv = {1'b0, space_advance_reg};
        else if (is_letter)
            adv = {1'b0, letter_width} + {5'b00000, letter_gap_reg};
        else if (is_latin)
            adv = {1'b0, latin_advance_reg};
        else
            adv = 9'd0;
    end

    // Fit the code point against the line
    logic [16:0]      width_sum;
    logic             fits;
    logic [POS_W:0]   byte_pos_sum;
    logic [POS_W:0]   stop_pos_sum;
    logic [POS_W-1:0] byte_pos_sat;
    logic [POS_W-1:0] stop_pos_sat;
    logic [POS_W-1:0] first_cp_sat;
    logic [15:0]      used_upd;
    logic [POS_W-1:0] byte_pos_upd;
    logic [POS_W-1:0] stop_pos_upd;
    logic [POS_W-1:0] space_pos_upd;
    logic             space_seen_upd;
    logic [1:0]       mode_upd;

    always_comb
    begin
        width_sum    = {1'b0, used_reg} + {8'h00, adv};
        fits         = (width_sum <= {1'b0, line_width_reg});
        byte_pos_sum = {1'b0, byte_pos_reg} + (POS_W + 1)'(cp_bytes);
        stop_pos_sum = {1'b0, stop_pos_reg} + (POS_W + 1)'(cp_bytes);
        byte_pos_sat = (byte_pos_sum > (POS_W + 1)'(MAX_BYTES)) ?
                       POS_W'(MAX_BYTES) : byte_pos_sum[POS_W-1:0];
        stop_pos_sat = (stop_pos_sum > (POS_W + 1)'(MAX_BYTES)) ?
                       POS_W'(MAX_BYTES) : stop_pos_sum[POS_W-1:0];
        first_cp_sat = POS_W'(cp_bytes);

        used_upd       = used_reg;
        byte_pos_upd   = byte_pos_reg;
        stop_pos_upd   = stop_pos_reg;
        space_pos_upd  = space_pos_reg;
        space_seen_upd = space_seen_reg;
        mode_upd       = mode_reg;

        if (has_cp)
        begin
            unique case (mode_reg)
                u8lb_pkg::MODE_FIT:
                begin
                    if (!fits)
                    begin
                        priority if (space_seen_reg && (space_pos_reg != '0))
                        begin
                            stop_pos_upd = space_pos_reg;
                            mode_upd     = u8lb_pkg::MODE_DONE;
                        end
                        else if (byte_pos_reg == '0)
                        begin
                            // not even the first character fits: take the whole word
                            stop_pos_upd = first_cp_sat;
                            mode_upd     = is_space ? u8lb_pkg::MODE_DONE : u8lb_pkg::MODE_WORD;
                        end
                        else
                        begin
                            stop_pos_upd = byte_pos_reg;
                            mode_upd     = u8lb_pkg::MODE_DONE;
                        end
                    end
                    else
                    begin
                        if (is_space)
                        begin
                            space_pos_upd  = byte_pos_reg;
                            space_seen_upd = 1'b1;
                        end
                        used_upd     = width_sum[15:0];
                        byte_pos_upd = byte_pos_sat;
                        stop_pos_upd = byte_pos_sat;
                    end
                end
                u8lb_pkg::MODE_WORD:
                begin
                    if (is_space)
                        mode_upd = u8lb_pkg::MODE_DONE;
                    else
                        stop_pos_upd = stop_pos_sat;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Commit string state; clear it once the string is finished
    logic             emit;
    logic [POS_W-1:0] emit_data;

    always_comb
    begin
        used_next       = used_reg;
        byte_pos_next   = byte_pos_reg;
        stop_pos_next   = stop_pos_reg;
        space_pos_next  = space_pos_reg;
        space_seen_next = space_seen_reg;
        mode_next       = mode_reg;
        pend_cnt_next   = pend_cnt_reg;
        flush_next      = flush_reg;
        for (int i = 0; i < 3; i++)
            pend_byte_next[i] = pend_byte_reg[i];
        emit      = 1'b0;
        emit_data = (line_width_reg == 16'd0) ? '0 : stop_pos_upd;

        if (text_step)
        begin
            if (win_last && (remain == 3'd0))
            begin
                emit            = 1'b1;
                used_next       = '0;
                byte_pos_next   = '0;
                stop_pos_next   = '0;
                space_pos_next  = '0;
                space_seen_next = 1'b0;
                mode_next       = u8lb_pkg::MODE_FIT;
                pend_cnt_next   = 2'd0;
                flush_next      = 1'b0;
                for (int i = 0; i < 3; i++)
                    pend_byte_next[i] = 8'h00;
            end
            else
            begin
                used_next       = used_upd;
                byte_pos_next   = byte_pos_upd;
                stop_pos_next   = stop_pos_upd;
                space_pos_next  = space_pos_upd;
                space_seen_next = space_seen_upd;
                mode_next       = mode_upd;
                pend_cnt_next   = remain[1:0];
                flush_next      = win_last;
                for (int i = 0; i < 3; i++)
                    pend_byte_next[i] = pend_shift[i];
            end
        end
    end

    // Output register with skid entry behind it
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || m_tready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = emit;
                out_data_next  = emit_data;
            end
        end
        else if (emit)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = emit_data;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg      <= 16'd240;
            space_advance_reg   <= 8'd4;
            letter_gap_reg      <= 4'd1;
            latin_advance_reg   <= 8'd6;
            max_glyph_width_reg <= 8'd12;
            letter_first_reg    <= 16'd1488;
            letter_last_reg     <= 16'd1514;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                u8lb_pkg::REG_LINE_WIDTH:      line_width_reg      <= cfg_data;
                u8lb_pkg::REG_SPACE_ADVANCE:   space_advance_reg   <= cfg_data[7:0];
                u8lb_pkg::REG_LETTER_GAP:      letter_gap_reg      <= cfg_data[3:0];
                u8lb_pkg::REG_LATIN_ADVANCE:   latin_advance_reg   <= cfg_data[7:0];
                u8lb_pkg::REG_MAX_GLYPH_WIDTH: max_glyph_width_reg <= cfg_data[7:0];
                u8lb_pkg::REG_LETTER_FIRST:    letter_first_reg    <= cfg_data;
                u8lb_pkg::REG_LETTER_LAST:     letter_last_reg     <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Glyph table writes; slots past the table are dropped
    logic [8:0] slot_wide;
    assign slot_wide = {4'b0000, in_glyph_slot};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < GLYPH_SLOTS; i++)
                glyph_widths_reg[i] <= 8'h00;
        end
        else if (s_accept && (s_tuser == u8lb_pkg::OP_GLYPH) &&
                 (slot_wide < 9'(GLYPH_SLOTS)))
        begin
            glyph_widths_reg[slot_wide[SLOT_W-1:0]] <= in_glyph_pixels;
        end
    end

    // String state and output control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg       <= '0;
            byte_pos_reg   <= '0;
            stop_pos_reg   <= '0;
            space_pos_reg  <= '0;
            space_seen_reg <= 1'b0;
            mode_reg       <= u8lb_pkg::MODE_FIT;
            pend_cnt_reg   <= 2'd0;
            flush_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            used_reg       <= used_next;
            byte_pos_reg   <= byte_pos_next;
            stop_pos_reg   <= stop_pos_next;
            space_pos_reg  <= space_pos_next;
            space_seen_reg <= space_seen_next;
            mode_reg       <= mode_next;
            pend_cnt_reg   <= pend_cnt_next;
            flush_reg      <= flush_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Held bytes and result payload
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
            pend_byte_reg[i] <= pend_byte_next[i];
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    // Skid entry only fills behind a waiting output
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry full while output register empty");

    // A flush only runs with one or two bytes left behind the cut-off lead
    a_flush_pending: assert property (@(posedge clk) disable iff (!rst_n)
        flush_reg |-> (pend_cnt_reg == 2'd1 || pend_cnt_reg == 2'd2))
        else $error("flush with unexpected number of held bytes");

    // A finished string leaves the scan state cleared
    a_clear_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> (byte_pos_reg == '0 && pend_cnt_reg == 2'd0 &&
                  mode_reg == u8lb_pkg::MODE_FIT && !flush_reg))
        else $error("string state not cleared after result");

    // Every result lands in the output register or the skid entry
    a_emit_lands: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> (out_valid_reg || skid_valid_reg))
        else $error("result dropped");

    // Stop and byte positions stay within the byte limit
    a_stop_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (stop_pos_reg <= POS_W'(MAX_BYTES)) && (byte_pos_reg <= POS_W'(MAX_BYTES)))
        else $error("byte position beyond limit");

endmodule
